// ===== rtl/ihwq_pkg.sv =====
// shared types and constants for the integral histogram window query block
package ihwq_pkg;

    localparam int MaxRows = 64;
    localparam int MaxCols = 64;
    localparam int Bins    = 256;

    localparam int RowW   = $clog2(MaxRows);
    localparam int ColW   = $clog2(MaxCols);
    localparam int BinW   = $clog2(Bins);
    localparam int CountW = 13;
    localparam int AddrW  = RowW + ColW + BinW;
    localparam int HistW  = 7;

    localparam logic [1:0] CfgRows = 2'd0;
    localparam logic [1:0] CfgCols = 2'd1;
    localparam logic [1:0] CfgSide = 2'd2;

    localparam logic ReqLoad  = 1'b0;
    localparam logic ReqQuery = 1'b1;

    // corner read order for a query
    localparam logic [1:0] CornerTl = 2'd0;
    localparam logic [1:0] CornerBr = 2'd1;
    localparam logic [1:0] CornerTr = 2'd2;
    localparam logic [1:0] CornerBl = 2'd3;

    typedef struct packed {
        logic             load_start;
        logic             load_bin_step;
        logic             load_finish;
        logic             query_start;
        logic             query_read;
        logic [1:0]       corner;
        logic             query_acc;
        logic             query_finish;
    } t_cmd;

    typedef struct packed {
        logic             bin_last;
    } t_status;

endpackage

// ===== rtl/ihwq_datapath.sv =====
// datapath: row histogram, integral memory, corner arithmetic and result register
module ihwq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [6:0]                    i_cfg_data,
    input  logic                          i_req_type,
    input  logic [7:0]                    i_pixel_value,
    input  logic [5:0]                    i_query_row,
    input  logic [5:0]                    i_query_col,
    input  logic [7:0]                    i_query_bin,
    input  ihwq_pkg::t_cmd                i_cmd,
    output ihwq_pkg::t_status             o_status,
    output logic [ihwq_pkg::CountW-1:0]   o_bin_count,
    output logic                          o_window_error
);

    logic [6:0] r_rows, r_cols;
    logic [5:0] r_side;
    logic [ihwq_pkg::RowW-1:0] r_load_row;
    logic [ihwq_pkg::ColW-1:0] r_load_col;
    logic [ihwq_pkg::BinW-1:0] r_bin, r_pix;

    logic [ihwq_pkg::HistW-1:0]   hist_mem [ihwq_pkg::Bins];
    logic [ihwq_pkg::CountW-1:0]  int_mem  [1 << ihwq_pkg::AddrW];
    logic [ihwq_pkg::Bins-1:0]    r_hist_valid;

    logic [ihwq_pkg::HistW-1:0]  r_hist_rd;
    logic [ihwq_pkg::CountW-1:0] r_up_rd, r_q_rd;
    logic                        r_step_v, r_step_v2;
    logic [ihwq_pkg::BinW-1:0]   r_bin_d, r_bin_d2;
    logic [ihwq_pkg::CountW-1:0] r_acc;
    logic [ihwq_pkg::RowW-1:0]   r_tr;
    logic [ihwq_pkg::ColW-1:0]   r_tc;
    logic [5:0]                  r_qside;
    logic                        r_qerr;
    logic                        r_acc_v;
    logic [1:0]                  r_corner_d;

    logic [6:0] eff_rows, eff_cols;
    logic [6:0] half, cr, cc, tr_w, tc_w;
    logic [ihwq_pkg::HistW-1:0] hist_val, hist_new;
    logic [ihwq_pkg::RowW-1:0]  rd_row;
    logic [ihwq_pkg::ColW-1:0]  rd_col;
    logic [6:0]                 row_sum, col_sum;
    logic [ihwq_pkg::AddrW-1:0] up_addr, wr_addr, q_addr;
    logic [ihwq_pkg::CountW-1:0] wr_data;
    logic                        is_pix;

    always_comb begin
        eff_rows = (r_rows < 7'd2) ? 7'd2 : (r_rows > 7'd64) ? 7'd64 : r_rows;
        eff_cols = (r_cols < 7'd2) ? 7'd2 : (r_cols > 7'd64) ? 7'd64 : r_cols;
        half = {2'b0, r_side[5:1]};
        cr = ({1'b0, i_query_row} > half) ? {1'b0, i_query_row} - half : 7'd0;
        cc = ({1'b0, i_query_col} > half) ? {1'b0, i_query_col} - half : 7'd0;
        tr_w = (cr + {1'b0, r_side} >= eff_rows) ? eff_rows - {1'b0, r_side} - 7'd1 : cr;
        tc_w = (cc + {1'b0, r_side} >= eff_cols) ? eff_cols - {1'b0, r_side} - 7'd1 : cc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64;
            r_cols <= 7'd64;
            r_side <= 6'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ihwq_pkg::CfgRows: r_rows <= i_cfg_data;
                ihwq_pkg::CfgCols: r_cols <= i_cfg_data;
                ihwq_pkg::CfgSide: r_side <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign o_status.bin_last = (r_bin == ihwq_pkg::BinW'(ihwq_pkg::Bins - 1));

    // load sweep: stage 0 reads hist and upper row, stage 1 writes
    assign up_addr = {r_load_row - ihwq_pkg::RowW'(1), r_load_col, r_bin};
    assign wr_addr = {r_load_row, r_load_col, r_bin_d};
    assign is_pix  = (r_bin_d == r_pix);
    assign hist_val = (r_load_col == '0 || !r_hist_valid[r_bin_d]) ? '0 : r_hist_rd;
    assign hist_new = is_pix ? hist_val + ihwq_pkg::HistW'(1) : hist_val;
    assign wr_data = ihwq_pkg::CountW'(hist_new)
                   + ((r_load_row == '0) ? '0 : r_up_rd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bin_step) begin
            r_hist_rd <= hist_mem[r_bin];
            r_up_rd   <= int_mem[up_addr];
        end
        if (r_step_v) begin
            hist_mem[r_bin_d] <= hist_new;
            int_mem[wr_addr]  <= wr_data;
        end
        r_bin_d <= r_bin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_row   <= '0;
            r_load_col   <= '0;
            r_bin        <= '0;
            r_step_v     <= 1'b0;
            r_step_v2    <= 1'b0;
            r_hist_valid <= '0;
        end else begin
            r_step_v  <= i_cmd.load_bin_step;
            r_step_v2 <= r_step_v;
            if (i_cmd.load_start) begin
                r_bin <= '0;
                r_pix <= i_pixel_value;
            end else if (i_cmd.load_bin_step) begin
                r_bin <= r_bin + ihwq_pkg::BinW'(1);
            end
            if (r_step_v) r_hist_valid[r_bin_d] <= 1'b1;
            if (i_cmd.load_finish) begin
                if ({1'b0, r_load_col} + 7'd1 >= eff_cols) begin
                    r_load_col <= '0;
                    r_load_row <= ({1'b0, r_load_row} + 7'd1 >= eff_rows)
                                ? '0 : r_load_row + ihwq_pkg::RowW'(1);
                end else begin
                    r_load_col <= r_load_col + ihwq_pkg::ColW'(1);
                end
            end
        end
    end

    // query: four reads of the integral memory, accumulated one a cycle
    always_comb begin
        row_sum = {1'b0, r_tr} + {1'b0, r_qside};
        col_sum = {1'b0, r_tc} + {1'b0, r_qside};
        unique case (i_cmd.corner)
            ihwq_pkg::CornerTl: begin rd_row = r_tr; rd_col = r_tc; end
            ihwq_pkg::CornerBr: begin
                rd_row = row_sum[ihwq_pkg::RowW-1:0];
                rd_col = col_sum[ihwq_pkg::ColW-1:0];
            end
            ihwq_pkg::CornerTr: begin rd_row = r_tr; rd_col = col_sum[ihwq_pkg::ColW-1:0]; end
            default: begin rd_row = row_sum[ihwq_pkg::RowW-1:0]; rd_col = r_tc; end
        endcase
        q_addr = {rd_row, rd_col, r_bin_d2};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_tr     <= tr_w[ihwq_pkg::RowW-1:0];
            r_tc     <= tc_w[ihwq_pkg::ColW-1:0];
            r_qside  <= r_side;
            r_bin_d2 <= i_query_bin;
            r_qerr   <= ({1'b0, r_side} >= eff_rows) || ({1'b0, r_side} >= eff_cols);
        end
        if (i_cmd.query_read) begin
            r_q_rd     <= int_mem[q_addr];
            r_corner_d <= i_cmd.corner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v <= 1'b0;
        end else begin
            r_acc_v <= i_cmd.query_read;
        end
        if (i_cmd.query_start) begin
            r_acc <= '0;
        end else if (r_acc_v) begin
            if (r_corner_d == ihwq_pkg::CornerTl || r_corner_d == ihwq_pkg::CornerBr)
                r_acc <= r_acc + r_q_rd;
            else
                r_acc <= r_acc - r_q_rd;
        end
        if (i_cmd.query_finish) begin
            o_bin_count    <= r_qerr ? '0 : r_acc;
            o_window_error <= r_qerr;
        end
    end

    logic unused_ok;
    assign unused_ok = i_req_type ^ r_step_v2 ^ i_cmd.query_acc;

endmodule

// ===== rtl/ihwq_ctrl.sv =====
// controller: sequences load sweeps and query reads, owns the stream handshake
module ihwq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_req_type,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_out_ready,
    input  ihwq_pkg::t_status    i_status,
    output ihwq_pkg::t_cmd       o_cmd
);

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StLoad  = 3'd1;
    localparam logic [2:0] StDrain = 3'd2;
    localparam logic [2:0] StQuery = 3'd3;
    localparam logic [2:0] StAcc   = 3'd4;
    localparam logic [2:0] StDone  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_corner, n_corner;
    logic       r_out_v, n_out_v;
    logic       accept;

    assign o_ready = (r_state == StIdle);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_v;

    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        n_out_v  = r_out_v && !i_out_ready;
        o_cmd    = '0;
        o_cmd.corner = r_corner;
        unique case (r_state)
            StIdle: begin
                if (accept && i_req_type == ihwq_pkg::ReqLoad) begin
                    o_cmd.load_start = 1'b1;
                    n_state = StLoad;
                end else if (accept) begin
                    o_cmd.query_start = 1'b1;
                    n_corner = ihwq_pkg::CornerTl;
                    n_state = StQuery;
                end
            end
            StLoad: begin
                o_cmd.load_bin_step = 1'b1;
                if (i_status.bin_last) n_state = StDrain;
            end
            StDrain: begin
                o_cmd.load_finish = 1'b1;
                n_state = StIdle;
            end
            StQuery: begin
                o_cmd.query_read = 1'b1;
                n_corner = r_corner + 2'd1;
                if (r_corner == ihwq_pkg::CornerBl) n_state = StAcc;
            end
            StAcc: begin
                o_cmd.query_acc = 1'b1;
                n_state = StDone;
            end
            StDone: begin
                if (!r_out_v || i_out_ready) begin
                    o_cmd.query_finish = 1'b1;
                    n_out_v = 1'b1;
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_corner <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
            r_out_v  <= n_out_v;
        end
    end

endmodule

// ===== rtl/integral_histogram_window_query_top.sv =====
// top level of the integral histogram window query block
// A load item is accepted, then sweeps the grey levels one a cycle through the single write
// port of the integral memory, and a final drain step writes the last level. A query item
// is accepted, then makes four reads of the integral memory one a cycle, an accumulate and
// a write of the result register; it holds in that last step while an earlier result
// still waits. One item is worked at a time; a finished result waits in the output register
// while the next item is taken. Queries are valid only after a full image has been loaded.
module integral_histogram_window_query_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [6:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // pixel_value, query_row, query_col, query_bin, zero fill
    input  logic         s_axis_tuser,   // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata    // bin_count, window_error, zero fill
);

    ihwq_pkg::t_cmd    cmd;
    ihwq_pkg::t_status status;
    logic [12:0]       bin_count;
    logic              window_error;
    logic [3:0]        unused_pad;

    assign unused_pad = s_axis_tdata[31:28];

    ihwq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ihwq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (s_axis_tuser ^ (^unused_pad & 1'b0)),
        .i_pixel_value  (s_axis_tdata[7:0]),
        .i_query_row    (s_axis_tdata[13:8]),
        .i_query_col    (s_axis_tdata[19:14]),
        .i_query_bin    (s_axis_tdata[27:20]),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_bin_count    (bin_count),
        .o_window_error (window_error)
    );

    assign m_axis_tdata = {2'b00, window_error, bin_count};

endmodule
